[sv/dpb_pkg.sv]
// Shared types and constants for the depth pixel back-projection block.
`default_nettype none
package dpb_pkg;

    localparam int DEPTH_W    = 16;
    localparam int SIDE_W     = 13;
    localparam int CNT_W      = 12;
    localparam int CENTER_W   = 16;
    localparam int INV_W      = 24;
    localparam int INV_HALF_W = INV_W / 2;
    localparam int FRAC_W     = 4;
    localparam int POS_W      = SIDE_W + FRAC_W;
    localparam int DIFF_W     = POS_W + 1;
    localparam int MAG_W      = POS_W;
    localparam int PROD_A_W   = DEPTH_W + MAG_W;
    localparam int PROD_P_W   = PROD_A_W + INV_HALF_W;
    localparam int COORD_W    = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int NUM_AXES    = 2;

    localparam logic [SIDE_W-1:0] MAX_SIDE = SIDE_W'(4096);

    localparam logic [SIDE_W-1:0]   RESET_FRAME_WIDTH  = SIDE_W'(640);
    localparam logic [SIDE_W-1:0]   RESET_FRAME_HEIGHT = SIDE_W'(480);
    localparam logic [CENTER_W-1:0] RESET_CENTER_X     = CENTER_W'(5120);
    localparam logic [CENTER_W-1:0] RESET_CENTER_Y     = CENTER_W'(3840);
    localparam logic [INV_W-1:0]    RESET_INV_FOCAL    = INV_W'(32263);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FRAME_WIDTH  = 3'd0,
        CFG_FRAME_HEIGHT = 3'd1,
        CFG_CENTER_X     = 3'd2,
        CFG_CENTER_Y     = 3'd3,
        CFG_INV_FOCAL_X  = 3'd4,
        CFG_INV_FOCAL_Y  = 3'd5
    } dpb_cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_P,
        ST_DONE
    } dpb_state_t;

    typedef struct packed {
        logic load_in;
        logic mul_a;
        logic mul_p;
        logic load_out;
    } dpb_cmd_t;

endpackage
`default_nettype wire

[sv/dpb_ctrl.sv]
// Controller: sequences one pixel through the datapath and tracks the output slot.
`default_nettype none
module dpb_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output dpb_pkg::dpb_cmd_t      cmd
);

    dpb_pkg::dpb_state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= dpb_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            dpb_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = dpb_pkg::ST_MUL_A;
                end
            end
            dpb_pkg::ST_MUL_A: begin
                cmd.mul_a  = 1'b1;
                state_next = dpb_pkg::ST_MUL_P;
            end
            dpb_pkg::ST_MUL_P: begin
                cmd.mul_p  = 1'b1;
                state_next = dpb_pkg::ST_DONE;
            end
            dpb_pkg::ST_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = dpb_pkg::ST_IDLE;
                end
            end
            default: state_next = dpb_pkg::ST_IDLE;
        endcase

        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_valid = out_valid_reg;

endmodule
`default_nettype wire

[sv/dpb_datapath.sv]
// Datapath: config registers, pixel counters, projection arithmetic, output register.
`default_nettype none
module dpb_datapath (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire dpb_pkg::dpb_cmd_t                     cmd,
    input  wire logic                                  cfg_valid,
    input  wire logic [dpb_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  wire logic [dpb_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  wire logic [dpb_pkg::DEPTH_W-1:0]           s_depth,
    output logic signed [dpb_pkg::COORD_W-1:0]         m_point_x,
    output logic signed [dpb_pkg::COORD_W-1:0]         m_point_y,
    output logic [dpb_pkg::DEPTH_W-1:0]                m_point_z,
    output logic                                       m_frame_last
);

    localparam int SUM_W = dpb_pkg::PROD_P_W + 1;
    localparam int R_W   = SUM_W - dpb_pkg::INV_HALF_W;

    logic [dpb_pkg::SIDE_W-1:0]   fw_reg, fh_reg;
    logic [dpb_pkg::CENTER_W-1:0] center_reg [dpb_pkg::NUM_AXES];
    logic [dpb_pkg::INV_W-1:0]    inv_reg    [dpb_pkg::NUM_AXES];

    logic [dpb_pkg::CNT_W-1:0] col_reg, col_next;
    logic [dpb_pkg::CNT_W-1:0] row_reg, row_next;

    logic [dpb_pkg::DEPTH_W-1:0]  depth_reg;
    logic                         last_reg;
    logic                         neg_reg   [dpb_pkg::NUM_AXES];
    logic [dpb_pkg::MAG_W-1:0]    mag_reg   [dpb_pkg::NUM_AXES];
    logic [dpb_pkg::PROD_A_W-1:0] a_reg     [dpb_pkg::NUM_AXES];
    logic [dpb_pkg::PROD_P_W-1:0] phi_reg   [dpb_pkg::NUM_AXES];
    logic [dpb_pkg::PROD_P_W-1:0] plo_reg   [dpb_pkg::NUM_AXES];

    logic [dpb_pkg::COORD_W-1:0]  coord_reg [dpb_pkg::NUM_AXES];
    logic [dpb_pkg::DEPTH_W-1:0]  z_reg;
    logic                         frame_last_reg;

    logic [dpb_pkg::SIDE_W-1:0]   w_eff, h_eff, col1, row1;
    logic                         row_end, frame_end;
    logic [dpb_pkg::SIDE_W-1:0]   pos1      [dpb_pkg::NUM_AXES];
    logic [dpb_pkg::DIFF_W-1:0]   diff      [dpb_pkg::NUM_AXES];
    logic [dpb_pkg::COORD_W-1:0]  coord_new [dpb_pkg::NUM_AXES];

    function automatic logic [dpb_pkg::SIDE_W-1:0] eff_side(
        input logic [dpb_pkg::SIDE_W-1:0] v
    );
        logic [dpb_pkg::SIDE_W-1:0] r;
        priority if (v == '0) begin
            r = dpb_pkg::SIDE_W'(1);
        end else if (v > dpb_pkg::MAX_SIDE) begin
            r = dpb_pkg::MAX_SIDE;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // round Q.28 to Q.4 (halves away from zero on the magnitude), then saturate
    function automatic logic [dpb_pkg::COORD_W-1:0] round_sat(
        input logic [dpb_pkg::PROD_P_W-1:0] phi,
        input logic [dpb_pkg::PROD_P_W-1:0] plo,
        input logic                         neg
    );
        logic [SUM_W-1:0]              lo_rnd;
        logic [SUM_W-1:0]              sum;
        logic [R_W-1:0]                r;
        logic [dpb_pkg::COORD_W-1:0]   res;
        lo_rnd = SUM_W'(plo) + (SUM_W'(1) << (dpb_pkg::INV_W - 1));
        sum    = SUM_W'(phi) + (lo_rnd >> dpb_pkg::INV_HALF_W);
        r      = R_W'(sum >> dpb_pkg::INV_HALF_W);
        if (neg) begin
            if (r >= (R_W'(1) << (dpb_pkg::COORD_W - 1))) begin
                res = {1'b1, {(dpb_pkg::COORD_W-1){1'b0}}};
            end else begin
                res = '0 - r[dpb_pkg::COORD_W-1:0];
            end
        end else begin
            if (r > R_W'({1'b0, {(dpb_pkg::COORD_W-1){1'b1}}})) begin
                res = {1'b0, {(dpb_pkg::COORD_W-1){1'b1}}};
            end else begin
                res = r[dpb_pkg::COORD_W-1:0];
            end
        end
        return res;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg        <= dpb_pkg::RESET_FRAME_WIDTH;
            fh_reg        <= dpb_pkg::RESET_FRAME_HEIGHT;
            center_reg[0] <= dpb_pkg::RESET_CENTER_X;
            center_reg[1] <= dpb_pkg::RESET_CENTER_Y;
            inv_reg[0]    <= dpb_pkg::RESET_INV_FOCAL;
            inv_reg[1]    <= dpb_pkg::RESET_INV_FOCAL;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                dpb_pkg::CFG_FRAME_WIDTH:  fw_reg        <= cfg_data[dpb_pkg::SIDE_W-1:0];
                dpb_pkg::CFG_FRAME_HEIGHT: fh_reg        <= cfg_data[dpb_pkg::SIDE_W-1:0];
                dpb_pkg::CFG_CENTER_X:     center_reg[0] <= cfg_data[dpb_pkg::CENTER_W-1:0];
                dpb_pkg::CFG_CENTER_Y:     center_reg[1] <= cfg_data[dpb_pkg::CENTER_W-1:0];
                dpb_pkg::CFG_INV_FOCAL_X:  inv_reg[0]    <= cfg_data[dpb_pkg::INV_W-1:0];
                dpb_pkg::CFG_INV_FOCAL_Y:  inv_reg[1]    <= cfg_data[dpb_pkg::INV_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_eff     = eff_side(fw_reg);
        h_eff     = eff_side(fh_reg);
        col1      = dpb_pkg::SIDE_W'(col_reg) + dpb_pkg::SIDE_W'(1);
        row1      = dpb_pkg::SIDE_W'(row_reg) + dpb_pkg::SIDE_W'(1);
        row_end   = col1 >= w_eff;
        frame_end = row_end && (row1 >= h_eff);
        pos1[0]   = col1;
        pos1[1]   = row1;
        for (int i = 0; i < dpb_pkg::NUM_AXES; i++) begin
            diff[i] = {1'b0, pos1[i], {dpb_pkg::FRAC_W{1'b0}}}
                    - dpb_pkg::DIFF_W'(center_reg[i]);
            coord_new[i] = round_sat(phi_reg[i], plo_reg[i], neg_reg[i]);
        end
        if (row_end) begin
            col_next = '0;
            row_next = frame_end ? '0 : row1[dpb_pkg::CNT_W-1:0];
        end else begin
            col_next = col1[dpb_pkg::CNT_W-1:0];
            row_next = row_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (cmd.load_in) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            depth_reg <= s_depth;
            last_reg  <= frame_end;
            for (int i = 0; i < dpb_pkg::NUM_AXES; i++) begin
                neg_reg[i] <= diff[i][dpb_pkg::DIFF_W-1];
                mag_reg[i] <= diff[i][dpb_pkg::DIFF_W-1]
                            ? dpb_pkg::MAG_W'('0 - diff[i])
                            : diff[i][dpb_pkg::MAG_W-1:0];
            end
        end
        if (cmd.mul_a) begin
            for (int i = 0; i < dpb_pkg::NUM_AXES; i++) begin
                a_reg[i] <= dpb_pkg::PROD_A_W'(depth_reg) * dpb_pkg::PROD_A_W'(mag_reg[i]);
            end
        end
        if (cmd.mul_p) begin
            for (int i = 0; i < dpb_pkg::NUM_AXES; i++) begin
                phi_reg[i] <= dpb_pkg::PROD_P_W'(a_reg[i])
                            * dpb_pkg::PROD_P_W'(inv_reg[i][dpb_pkg::INV_W-1:dpb_pkg::INV_HALF_W]);
                plo_reg[i] <= dpb_pkg::PROD_P_W'(a_reg[i])
                            * dpb_pkg::PROD_P_W'(inv_reg[i][dpb_pkg::INV_HALF_W-1:0]);
            end
        end
        if (cmd.load_out) begin
            coord_reg[0]   <= coord_new[0];
            coord_reg[1]   <= coord_new[1];
            z_reg          <= depth_reg;
            frame_last_reg <= last_reg;
        end
    end

    assign m_point_x    = $signed(coord_reg[0]);
    assign m_point_y    = $signed(coord_reg[1]);
    assign m_point_z    = z_reg;
    assign m_frame_last = frame_last_reg;

endmodule
`default_nettype wire

[sv/depth_pixel_backprojection_top.sv]
// Each pixel runs the controller's three-step sequence (load, depth*offset multiply,
//   reciprocal multiply) plus the output load, which sets m_valid and waits while an
//   older result is still stalled. No new input is taken until the controller is idle.
// A result waiting in the output register does not block the next input transaction.
// Reset (aresetn low, synchronous): counters to zero (column one/row one), config
//   registers to defaults, controller idle, output register empty.
`default_nettype none
module depth_pixel_backprojection_top (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [dpb_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  wire logic [dpb_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic [dpb_pkg::DEPTH_W-1:0]           s_depth,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic signed [dpb_pkg::COORD_W-1:0]         m_point_x,
    output logic signed [dpb_pkg::COORD_W-1:0]         m_point_y,
    output logic [dpb_pkg::DEPTH_W-1:0]                m_point_z,
    output logic                                       m_frame_last
);

    dpb_pkg::dpb_cmd_t cmd;

    assign cfg_ready = 1'b1;

    dpb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    dpb_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_depth      (s_depth),
        .m_point_x    (m_point_x),
        .m_point_y    (m_point_y),
        .m_point_z    (m_point_z),
        .m_frame_last (m_frame_last)
    );

endmodule
`default_nettype wire

[sv/dpb_checker.sv]
// Port-level checker for the back-projection block, bound to the top level.
`default_nettype none
module dpb_checker (
    input wire logic                                  aclk,
    input wire logic                                  aresetn,
    input wire logic                                  s_valid,
    input wire logic                                  s_ready,
    input wire logic                                  m_valid,
    input wire logic                                  m_ready,
    input wire logic signed [dpb_pkg::COORD_W-1:0]    m_point_x,
    input wire logic signed [dpb_pkg::COORD_W-1:0]    m_point_y,
    input wire logic [dpb_pkg::DEPTH_W-1:0]           m_point_z,
    input wire logic                                  m_frame_last
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_point_x) && $stable(m_point_y)
            && $stable(m_point_z) && $stable(m_frame_last))
        else $error("result changed while stalled");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transaction taken while a pixel is in flight");

    a_zero_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_point_z == '0) |-> (m_point_x == '0) && (m_point_y == '0))
        else $error("zero depth gave a nonzero coordinate");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind depth_pixel_backprojection_top dpb_checker u_dpb_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_point_x    (m_point_x),
    .m_point_y    (m_point_y),
    .m_point_z    (m_point_z),
    .m_frame_last (m_frame_last)
);
`default_nettype wire
